// ===== hw/rtl/rchc_pkg.sv =====
// shared types and constants for the rtmp chunk header completion core
package rchc_pkg;

    localparam int TABLE_ENTRIES = 512;
    localparam int TBL_AW        = $clog2(TABLE_ENTRIES);

    localparam int ID_W   = 17;
    localparam int LEN_W  = 24;
    localparam int TS_W   = 63;
    localparam int DLT_W  = 32;
    localparam int TYP_W  = 8;
    localparam int STR_W  = 32;
    localparam int WIRE_W = 27;
    localparam int HDR_W  = 24;
    localparam int CFG_W  = 24;
    localparam int CNT_W  = $clog2(LEN_W + 1);

    localparam logic [1:0] FMT_FULL   = 2'd0;
    localparam logic [1:0] FMT_LENGTH = 2'd1;
    localparam logic [1:0] FMT_TIME   = 2'd2;
    localparam logic [1:0] FMT_CONT   = 2'd3;

    localparam logic [0:0] REG_CHUNK_SIZE = 1'b0;
    localparam logic [0:0] REG_MAX_LEN    = 1'b1;

    localparam logic [CFG_W-1:0] CHUNK_SIZE_RST = 24'd128;
    localparam logic [CFG_W-1:0] MAX_LEN_RST    = 24'hFFFFFF;

    localparam logic [7:0]      HDR_FMT3      = 8'hC0;
    localparam logic [7:0]      HDR_FMT3_WIDE = 8'hC1;
    localparam logic [ID_W-1:0] ID_OFFSET     = 17'd64;
    localparam logic [2:0]      EXT_HDR_BYTES = 3'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_PREV  = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_BEYOND   = 2'd3
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [TS_W-1:0]   ts;
        logic [DLT_W-1:0]  delta;
        logic [LEN_W-1:0]  len;
        logic [TYP_W-1:0]  typ;
        logic [STR_W-1:0]  strm;
    } t_entry;

    typedef struct packed {
        logic load;
        logic clear_wr;
        logic comp1;
        logic comp2;
        logic div_start;
        logic wire_calc;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic err;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/rchc_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module rchc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rchc_pkg::LEN_W-1:0] i_dividend,
    input  logic [rchc_pkg::LEN_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [rchc_pkg::LEN_W-1:0] o_quotient
);
    import rchc_pkg::*;

    logic [LEN_W-1:0] r_q, n_q;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [LEN_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [LEN_W:0]   trial;
    logic             ge;

    always_comb begin
        trial  = {r_rem, r_q[LEN_W-1]};
        ge     = trial >= {1'b0, r_dvs};
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_dividend;
            n_rem  = '0;
            n_cnt  = CNT_W'(LEN_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? LEN_W'(trial - {1'b0, r_dvs}) : LEN_W'(trial);
            n_q   = {r_q[LEN_W-2:0], ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== hw/rtl/rchc_dpath.sv =====
// datapath: header table, completion arithmetic, size calculation, output register
module rchc_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rchc_pkg::t_cmd              i_cmd,
    output rchc_pkg::t_stat             o_stat,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_index,
    input  logic [rchc_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [1:0]                  i_chunk_format,
    input  logic [rchc_pkg::ID_W-1:0]   i_chunk_stream,
    input  logic [1:0]                  i_basic_size,
    input  logic [23:0]                 i_time_field,
    input  logic                        i_has_extended,
    input  logic [31:0]                 i_extended_time,
    input  logic [rchc_pkg::LEN_W-1:0]  i_message_length,
    input  logic [rchc_pkg::TYP_W-1:0]  i_message_type,
    input  logic [rchc_pkg::STR_W-1:0]  i_message_stream,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [1:0]                  o_status,
    output logic [rchc_pkg::TS_W-1:0]   o_full_timestamp,
    output logic [rchc_pkg::DLT_W-1:0]  o_full_delta,
    output logic [rchc_pkg::LEN_W-1:0]  o_full_length,
    output logic [rchc_pkg::TYP_W-1:0]  o_full_type,
    output logic [rchc_pkg::STR_W-1:0]  o_full_stream,
    output logic [rchc_pkg::WIRE_W-1:0] o_wire_payload_size,
    output logic [rchc_pkg::HDR_W-1:0]  o_continuation_header
);
    import rchc_pkg::*;

    logic [CFG_W-1:0]  r_chunk_size, r_max_len;

    logic [1:0]        r_fmt;
    logic [ID_W-1:0]   r_id;
    logic [1:0]        r_bsize;
    logic [23:0]       r_tfield;
    logic              r_ext;
    logic [31:0]       r_etime;
    logic [LEN_W-1:0]  r_mlen;
    logic [TYP_W-1:0]  r_mtype;
    logic [STR_W-1:0]  r_mstream;

    t_entry            r_mem [TABLE_ENTRIES];
    t_entry            r_rd;
    logic              mem_we;
    logic [TBL_AW-1:0] mem_addr;
    t_entry            mem_wdata;
    logic [TBL_AW-1:0] r_clr_addr;

    t_status           r_status, n_status;
    logic [TS_W-1:0]   r_last_ts;
    logic [DLT_W-1:0]  r_delta, n_delta;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [TYP_W-1:0]  r_typ, n_typ;
    logic [STR_W-1:0]  r_strm, n_strm;
    logic [31:0]       r_newtime;
    logic [31:0]       r_base;
    logic              r_roll, n_roll;
    logic              r_fresh, n_fresh;
    logic [TS_W-1:0]   r_ts, n_ts;
    logic [WIRE_W-1:0] r_wire, n_wire;

    logic [31:0]       newtime;
    logic [63:0]       ts_gap;
    logic              near;

    logic [LEN_W-1:0]  cs;
    logic              div_done;
    logic [LEN_W-1:0]  quotient;
    logic [LEN_W-1:0]  count;
    logic [1:0]        bsize_eff;
    logic [2:0]        contsize;
    logic [ID_W-1:0]   off;
    logic [HDR_W-1:0]  hdr;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [TS_W-1:0]   r_out_ts;
    logic [DLT_W-1:0]  r_out_delta;
    logic [LEN_W-1:0]  r_out_len;
    logic [TYP_W-1:0]  r_out_typ;
    logic [STR_W-1:0]  r_out_strm;
    logic [WIRE_W-1:0] r_out_wire;
    logic [HDR_W-1:0]  r_out_hdr;
    logic              ok_err;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_size <= CHUNK_SIZE_RST;
            r_max_len    <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CHUNK_SIZE: r_chunk_size <= i_cfg_data;
                REG_MAX_LEN:    r_max_len    <= i_cfg_data;
                default:        r_max_len    <= r_max_len;
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fmt     <= i_chunk_format;
            r_id      <= i_chunk_stream;
            r_bsize   <= i_basic_size;
            r_tfield  <= i_time_field;
            r_ext     <= i_has_extended;
            r_etime   <= i_extended_time;
            r_mlen    <= i_message_length;
            r_mtype   <= i_message_type;
            r_mstream <= i_message_stream;
        end
    end

    // header table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr_addr <= r_clr_addr + TBL_AW'(1);
        end
    end

    assign mem_we    = i_cmd.clear_wr || (i_cmd.finish && (r_status == ST_OK));
    assign mem_addr  = i_cmd.clear_wr ? r_clr_addr : r_id[TBL_AW-1:0];
    assign mem_wdata = i_cmd.clear_wr ? '0 : t_entry'{1'b1, r_ts, r_delta, r_len, r_typ, r_strm};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd <= r_mem[r_id[TBL_AW-1:0]];
    end

    // completion from the previous entry
    always_comb begin
        newtime  = r_ext ? r_etime : {8'd0, r_tfield};
        ts_gap   = {1'b0, r_rd.ts} - {32'd0, newtime};
        near     = ts_gap[63] ? ((&ts_gap[63:30]) && (|ts_gap[29:0]))
                              : (ts_gap[62:30] == '0);
        n_status = ST_OK;
        n_fresh  = 1'b0;
        n_roll   = 1'b0;
        n_delta  = '0;
        n_len    = r_mlen;
        n_typ    = r_mtype;
        n_strm   = r_mstream;
        if (r_id >= ID_W'(TABLE_ENTRIES)) begin
            n_status = ST_BEYOND;
        end else if (r_fmt != FMT_FULL && !r_rd.valid) begin
            n_status = ST_NO_PREV;
        end else if (r_fmt == FMT_FULL) begin
            n_fresh = 1'b1;
            n_roll  = r_rd.valid && !near;
        end else begin
            n_strm  = r_rd.strm;
            n_delta = (r_fmt == FMT_CONT) ? r_rd.delta : newtime;
            if (r_fmt != FMT_LENGTH) begin
                n_len = r_rd.len;
                n_typ = r_rd.typ;
            end
        end
    end

    always_comb begin
        if (r_fresh) begin
            n_ts = r_roll ? TS_W'({r_base, 31'd0} + {31'd0, r_newtime}) : {31'd0, r_newtime};
        end else begin
            n_ts = r_last_ts + {31'd0, r_delta};
        end
    end

    // size on the wire
    assign cs = (r_chunk_size == '0) ? LEN_W'(1) : r_chunk_size;

    rchc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_len - LEN_W'(1)),
        .i_divisor  (cs),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        bsize_eff = (r_bsize == 2'd0) ? 2'd1 : r_bsize;
        contsize  = {1'b0, bsize_eff} + (r_ext ? EXT_HDR_BYTES : 3'd0);
        count     = (r_len == '0) ? '0 : quotient;
        n_wire    = WIRE_W'(r_len) + WIRE_W'({3'd0, count} * {24'd0, contsize});
        off       = r_id - ID_OFFSET;
        case (bsize_eff)
            2'd1:    hdr = {16'd0, HDR_FMT3[7:6], r_id[5:0]};
            2'd2:    hdr = {8'd0, off[7:0], HDR_FMT3};
            default: hdr = {off[15:8], off[7:0], HDR_FMT3_WIDE};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.comp1) begin
            r_status  <= n_status;
            r_fresh   <= n_fresh;
            r_roll    <= n_roll;
            r_delta   <= n_delta;
            r_len     <= n_len;
            r_typ     <= n_typ;
            r_strm    <= n_strm;
            r_last_ts <= r_rd.ts;
            r_newtime <= newtime;
            r_base    <= r_rd.ts[62:31] + 32'd1;
        end
        if (i_cmd.comp2) begin
            r_ts <= n_ts;
        end
        if (i_cmd.wire_calc) begin
            r_wire <= n_wire;
            if (r_len > r_max_len) begin
                r_status <= ST_TOO_LONG;
            end
        end
    end

    // output register
    assign ok_err = (r_status == ST_NO_PREV) || (r_status == ST_BEYOND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status <= r_status;
            r_out_ts     <= ok_err ? '0 : r_ts;
            r_out_delta  <= ok_err ? '0 : r_delta;
            r_out_len    <= ok_err ? '0 : r_len;
            r_out_typ    <= ok_err ? '0 : r_typ;
            r_out_strm   <= ok_err ? '0 : r_strm;
            r_out_wire   <= ok_err ? '0 : r_wire;
            r_out_hdr    <= ok_err ? '0 : hdr;
        end
    end

    assign o_stat.clear_last = (r_clr_addr == TBL_AW'(TABLE_ENTRIES - 1));
    assign o_stat.err        = ok_err;
    assign o_stat.div_done   = div_done;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid           = r_out_valid;
    assign o_status              = r_out_status;
    assign o_full_timestamp      = r_out_ts;
    assign o_full_delta          = r_out_delta;
    assign o_full_length         = r_out_len;
    assign o_full_type           = r_out_typ;
    assign o_full_stream         = r_out_strm;
    assign o_wire_payload_size   = r_out_wire;
    assign o_continuation_header = r_out_hdr;

    a_write_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && !i_cmd.clear_wr) |-> (r_status == ST_OK))
        else $error("table updated for a failed header");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished request not presented");

endmodule

// ===== hw/rtl/rchc_ctrl.sv =====
// controller: table clearing after reset and per-request sequencing
module rchc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output rchc_pkg::t_cmd  o_cmd,
    input  rchc_pkg::t_stat i_stat
);
    import rchc_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_READ  = 8'b00000100,
        S_COMP1 = 8'b00001000,
        S_COMP2 = 8'b00010000,
        S_DIV   = 8'b00100000,
        S_WIRE  = 8'b01000000,
        S_DONE  = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                n_state = S_COMP1;
            end
            S_COMP1: begin
                o_cmd.comp1 = 1'b1;
                n_state     = S_COMP2;
            end
            S_COMP2: begin
                o_cmd.comp2 = 1'b1;
                if (i_stat.err) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_WIRE;
                end
            end
            S_WIRE: begin
                o_cmd.wire_calc = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.out_free)
        else $error("result written over an unread result");

    a_div_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> (r_state == S_DIV) && !i_stat.div_done)
        else $error("divider finished too early");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (o_in_stall && !o_cmd.load))
        else $error("request taken during table clear");

endmodule

// ===== hw/rtl/rtmp_chunk_header_completion_core.sv =====
// top level of the rtmp chunk header completion core
// After reset the header table is cleared one entry per cycle, during which no request
// is taken; configuration writes are accepted at any time. Each request then passes the
// read, two completion steps, the bit-serial divide of the message length less one by the
// chunk size, the wire size step and a result step that waits for a free output; one that
// fails the id or previous-header check skips the divide and wire size step. One request
// is in work at a time, and the next is accepted while a finished result waits in the output register.
module rtmp_chunk_header_completion_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_chunk_format,
    input  logic [16:0] i_chunk_stream,
    input  logic [1:0]  i_basic_size,
    input  logic [23:0] i_time_field,
    input  logic        i_has_extended,
    input  logic [31:0] i_extended_time,
    input  logic [23:0] i_message_length,
    input  logic [7:0]  i_message_type,
    input  logic [31:0] i_message_stream,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [62:0] o_full_timestamp,
    output logic [31:0] o_full_delta,
    output logic [23:0] o_full_length,
    output logic [7:0]  o_full_type,
    output logic [31:0] o_full_stream,
    output logic [26:0] o_wire_payload_size,
    output logic [23:0] o_continuation_header
);
    import rchc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rchc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    rchc_dpath u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_chunk_format        (i_chunk_format),
        .i_chunk_stream        (i_chunk_stream),
        .i_basic_size          (i_basic_size),
        .i_time_field          (i_time_field),
        .i_has_extended        (i_has_extended),
        .i_extended_time       (i_extended_time),
        .i_message_length      (i_message_length),
        .i_message_type        (i_message_type),
        .i_message_stream      (i_message_stream),
        .i_out_stall           (i_out_stall),
        .o_out_valid           (o_out_valid),
        .o_status              (o_status),
        .o_full_timestamp      (o_full_timestamp),
        .o_full_delta          (o_full_delta),
        .o_full_length         (o_full_length),
        .o_full_type           (o_full_type),
        .o_full_stream         (o_full_stream),
        .o_wire_payload_size   (o_wire_payload_size),
        .o_continuation_header (o_continuation_header)
    );

endmodule
